// ----- hdl/bfa_pkg.sv -----
// bfa_pkg: shared types and constants for the best-fit arena allocator
// no dependencies; used by bfa_div, best_fit_arena_allocator and bfa_chk

package bfa_pkg;

  // default module parameters
  localparam int ALIGN_BYTES_DEF = 8;
  localparam int ARENA_UNITS_DEF = 4096;

  // fixed field widths
  localparam int ACTION_W   = 2;
  localparam int REQ_W      = 16;
  localparam int PAY_W      = 15;
  localparam int OFFSET_W   = 15;
  localparam int ARENA_CFG_W = 13;
  localparam int HDR_CFG_W  = 4;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  // dividend width: request bytes plus alignment slack
  localparam int QW         = 17;

  // register reset values and header clamp bounds
  localparam logic [ARENA_CFG_W-1:0] ARENA_UNITS_RST = 13'd4096;
  localparam logic [HDR_CFG_W-1:0]   HEADER_UNITS_RST = 4'd4;
  localparam logic [HDR_CFG_W-1:0]   HDR_MIN = 4'd1;
  localparam logic [HDR_CFG_W-1:0]   HDR_MAX = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARENA_UNITS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_UNITS = 1'd1;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RESET  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DIV,
    S_FRD,
    S_FEV,
    S_FEND,
    S_MRD,
    S_MEV,
    S_MNX,
    S_SPLIT,
    S_TAKE,
    S_HRD,
    S_HEV,
    S_DONE
  } state_t;

endpackage

// ----- hdl/bfa_div.sv -----
// bfa_div: division by the constant alignment through a rounded-up reciprocal multiply
// depends on bfa_pkg for the dividend width

module bfa_div #(
  parameter int ALIGN_BYTES = bfa_pkg::ALIGN_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic [bfa_pkg::QW-1:0] num,
  output logic                  done,
  output logic [bfa_pkg::QW-1:0] quo,
  output logic                  rem_zero
);

  localparam int SH  = bfa_pkg::QW + $clog2(ALIGN_BYTES);
  localparam int RCW = bfa_pkg::QW + 2;
  localparam int PRW = bfa_pkg::QW + RCW;
  // reciprocal rounded up, exact for every dividend of QW bits
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(ALIGN_BYTES) - 64'sd1) /
                               longint'(ALIGN_BYTES);
  localparam logic [RCW-1:0] RECIP = RCW'(RECIP_L);

  logic                   pending;
  logic [bfa_pkg::QW-1:0] num_r;
  logic [PRW-1:0]         prod;

  // quotient by multiply and shift, remainder check by multiplying back
  assign prod     = PRW'(num_r) * PRW'(RECIP);
  assign rem_zero = (bfa_pkg::QW'(quo * bfa_pkg::QW'(ALIGN_BYTES)) == num_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      pending <= go;
      done    <= pending;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      num_r <= num;
    end
    if (pending) begin
      quo <= bfa_pkg::QW'(prod >> SH);
    end
  end

endmodule

// ----- hdl/best_fit_arena_allocator.sv -----
// best_fit_arena_allocator: top level, block store memory and control sequencer
// depends on bfa_pkg and bfa_div
//
// Usage: a transaction is accepted when start is high and busy is low; action,
// request_bytes and payload_offset are sampled then. Exactly one result comes
// back per transaction on granted, result_offset and coalesced, marked by done
// for one cycle; the receiver cannot stall it. action 0 allocates the smallest
// free block that fits (lowest offset on ties), merging free neighbors once if
// nothing fits; action 1 frees a block by payload byte offset; action 2 makes
// the arena one free block; action 3 returns all zeros.
// Rounding bytes to units uses a registered reciprocal multiply. Every block
// visit of a walk reads the block store, whose read data is registered. An
// allocate walks every block and, if nothing fits, makes a merge pass and a
// rescan; a free walks the blocks up to its target. One transaction is in flight
// at a time; busy stays high until done.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// arena reset. After rst the block builds the initial arena in S_INIT with busy
// high, then is ready; no done pulse is given for it.

module best_fit_arena_allocator #(
  parameter int ALIGN_BYTES = bfa_pkg::ALIGN_BYTES_DEF,
  parameter int ARENA_UNITS = bfa_pkg::ARENA_UNITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bfa_pkg::ACTION_W-1:0]    action,
  input  logic [bfa_pkg::REQ_W-1:0]       request_bytes,
  input  logic [bfa_pkg::PAY_W-1:0]       payload_offset,
  input  logic                            cfg_we,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            done,
  output logic                            granted,
  output logic [bfa_pkg::OFFSET_W-1:0]    result_offset,
  output logic                            coalesced
);

  localparam int QW = bfa_pkg::QW;
  localparam int AW = $clog2(ARENA_UNITS);
  localparam int PW = $clog2(ARENA_UNITS + 1);
  localparam int LW = (PW > bfa_pkg::ARENA_CFG_W) ? PW : bfa_pkg::ARENA_CFG_W;
  localparam int MW = (PW + 7 > bfa_pkg::OFFSET_W) ? PW + 7 : bfa_pkg::OFFSET_W;
  localparam int EW = AW + 1;

  bfa_pkg::state_t state, state_next;

  // configuration registers
  logic [bfa_pkg::ARENA_CFG_W-1:0] arena_units;
  logic [bfa_pkg::HDR_CFG_W-1:0]   header_units;

  // arena geometry latched at arena reset
  logic [PW-1:0]                   span;
  logic [bfa_pkg::HDR_CFG_W-1:0]   hdr;

  // transaction registers
  logic [bfa_pkg::ACTION_W-1:0]    act;
  logic                            report;
  logic [QW-1:0]                   units;
  logic [PW-1:0]                   off;
  logic [PW-1:0]                   nxt_r;
  logic [PW-1:0]                   target;
  logic [PW-1:0]                   where;
  logic [AW-1:0]                   best;
  logic [AW-1:0]                   cur_sz;
  logic                            found;
  logic                            merged;
  logic                            res_granted;
  logic [bfa_pkg::OFFSET_W-1:0]    res_offset;

  // block store: free bit over payload size, indexed by header unit offset
  logic [EW-1:0] mem [ARENA_UNITS];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW-1:0] mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [EW-1:0] mem_q;

  // divider
  logic          div_go;
  logic [QW-1:0] div_num;
  logic          div_done;
  logic [QW-1:0] div_quo;
  logic          div_rem_zero;

  // decoded read data and derived values
  logic          q_free;
  logic [AW-1:0] q_sz;
  logic [PW-1:0] walk_nxt;
  logic          fit_cand;
  logic          do_split;
  logic [PW-1:0] split_at;
  logic          free_ok;
  logic [LW-1:0] a_clamp;
  logic [bfa_pkg::HDR_CFG_W-1:0] h_clamp;
  logic          arena_ok;
  logic          accept;

  assign accept   = start && !busy;
  assign q_free   = mem_q[AW];
  assign q_sz     = mem_q[AW-1:0];
  assign walk_nxt = off + PW'(hdr) + PW'(q_sz);
  assign fit_cand = q_free && (QW'(q_sz) >= units) && (!found || (q_sz < best));
  assign do_split = (units < QW'(best)) && ((QW'(best) - units) >= (QW'(hdr) + QW'(1)));
  assign split_at = where + PW'(hdr) + PW'(units);
  assign free_ok  = div_rem_zero && (div_quo >= QW'(hdr)) &&
                    ((div_quo - QW'(hdr)) < QW'(span));

  // clamped geometry for an arena reset
  always_comb begin
    a_clamp = (LW'(arena_units) > LW'(ARENA_UNITS)) ? LW'(ARENA_UNITS) : LW'(arena_units);
    if (header_units < bfa_pkg::HDR_MIN) begin
      h_clamp = bfa_pkg::HDR_MIN;
    end else if (header_units > bfa_pkg::HDR_MAX) begin
      h_clamp = bfa_pkg::HDR_MAX;
    end else begin
      h_clamp = header_units;
    end
    arena_ok = (a_clamp > LW'(h_clamp));
  end

  // dividend: round bytes up for allocate, plain offset for free
  assign div_go  = accept && ((action == bfa_pkg::ACT_ALLOC) || (action == bfa_pkg::ACT_FREE));
  assign div_num = (action == bfa_pkg::ACT_ALLOC) ?
                   (QW'(request_bytes) + QW'(ALIGN_BYTES - 1)) : QW'(payload_offset);

  bfa_div #(
    .ALIGN_BYTES(ALIGN_BYTES)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .num      (div_num),
    .done     (div_done),
    .quo      (div_quo),
    .rem_zero (div_rem_zero)
  );

  // block store memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bfa_pkg::S_INIT:  state_next = report ? bfa_pkg::S_DONE : bfa_pkg::S_IDLE;
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          if (div_go) begin
            state_next = bfa_pkg::S_DIV;
          end else if (action == bfa_pkg::ACT_RESET) begin
            state_next = bfa_pkg::S_INIT;
          end else begin
            state_next = bfa_pkg::S_DONE;
          end
        end
      end
      bfa_pkg::S_DIV: begin
        if (div_done) begin
          if (act == bfa_pkg::ACT_ALLOC) begin
            state_next = bfa_pkg::S_FRD;
          end else if (free_ok) begin
            state_next = bfa_pkg::S_HRD;
          end else begin
            state_next = bfa_pkg::S_DONE;
          end
        end
      end
      bfa_pkg::S_FRD:  state_next = (off < span) ? bfa_pkg::S_FEV : bfa_pkg::S_FEND;
      bfa_pkg::S_FEV:  state_next = bfa_pkg::S_FRD;
      bfa_pkg::S_FEND: begin
        if (found) begin
          state_next = do_split ? bfa_pkg::S_SPLIT : bfa_pkg::S_TAKE;
        end else if (!merged) begin
          state_next = bfa_pkg::S_MRD;
        end else begin
          state_next = bfa_pkg::S_DONE;
        end
      end
      bfa_pkg::S_MRD:  state_next = (off < span) ? bfa_pkg::S_MEV : bfa_pkg::S_FRD;
      bfa_pkg::S_MEV:  state_next = (q_free && (walk_nxt < span)) ?
                                    bfa_pkg::S_MNX : bfa_pkg::S_MRD;
      bfa_pkg::S_MNX:  state_next = bfa_pkg::S_MRD;
      bfa_pkg::S_SPLIT: state_next = bfa_pkg::S_TAKE;
      bfa_pkg::S_TAKE: state_next = bfa_pkg::S_DONE;
      bfa_pkg::S_HRD:  state_next = (off < span) ? bfa_pkg::S_HEV : bfa_pkg::S_DONE;
      bfa_pkg::S_HEV: begin
        if ((off == target) || (off > target)) begin
          state_next = bfa_pkg::S_DONE;
        end else begin
          state_next = bfa_pkg::S_HRD;
        end
      end
      bfa_pkg::S_DONE: state_next = bfa_pkg::S_IDLE;
      default:         state_next = bfa_pkg::S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_re = 1'b0;
    mem_ra = off[AW-1:0];
    busy   = (state != bfa_pkg::S_IDLE);
    done   = (state == bfa_pkg::S_DONE);
    unique case (state)
      bfa_pkg::S_INIT: begin
        mem_we = arena_ok;
        mem_wa = '0;
        mem_wd = {1'b1, AW'(a_clamp - LW'(h_clamp))};
      end
      bfa_pkg::S_FRD, bfa_pkg::S_MRD, bfa_pkg::S_HRD: begin
        mem_re = (off < span);
      end
      bfa_pkg::S_MEV: begin
        mem_re = q_free && (walk_nxt < span);
        mem_ra = walk_nxt[AW-1:0];
      end
      bfa_pkg::S_MNX: begin
        mem_we = q_free;
        mem_wa = off[AW-1:0];
        mem_wd = {1'b1, cur_sz + AW'(hdr) + q_sz};
      end
      bfa_pkg::S_SPLIT: begin
        mem_we = 1'b1;
        mem_wa = split_at[AW-1:0];
        mem_wd = {1'b1, best - AW'(units) - AW'(hdr)};
      end
      bfa_pkg::S_TAKE: begin
        mem_we = 1'b1;
        mem_wa = where[AW-1:0];
        mem_wd = {1'b0, do_split ? AW'(units) : best};
      end
      bfa_pkg::S_HEV: begin
        mem_we = (off == target) && !q_free;
        mem_wa = off[AW-1:0];
        mem_wd = {1'b1, q_sz};
      end
      default: begin
      end
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bfa_pkg::S_INIT;
      report       <= 1'b0;
      arena_units  <= bfa_pkg::ARENA_UNITS_RST;
      header_units <= bfa_pkg::HEADER_UNITS_RST;
    end else begin
      state <= state_next;
      if (accept) begin
        report <= 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          bfa_pkg::CFG_ARENA_UNITS:  arena_units  <= cfg_data;
          bfa_pkg::CFG_HEADER_UNITS: header_units <= cfg_data[bfa_pkg::HDR_CFG_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload byte offset of a block head, truncated to the port width
  function automatic logic [bfa_pkg::OFFSET_W-1:0] res_offset_calc(
    input logic [PW-1:0] head,
    input logic [bfa_pkg::HDR_CFG_W-1:0] h
  );
    logic [MW-1:0] prod;
    prod = (MW'(head) + MW'(h)) * MW'(ALIGN_BYTES);
    return prod[bfa_pkg::OFFSET_W-1:0];
  endfunction

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      bfa_pkg::S_INIT: begin
        hdr         <= h_clamp;
        span        <= arena_ok ? PW'(a_clamp) : '0;
        res_granted <= 1'b1;
      end
      bfa_pkg::S_IDLE: begin
        if (accept) begin
          act         <= action;
          off         <= '0;
          found       <= 1'b0;
          merged      <= 1'b0;
          res_granted <= 1'b0;
          res_offset  <= '0;
        end
      end
      bfa_pkg::S_DIV: begin
        units  <= div_quo;
        target <= PW'(div_quo - QW'(hdr));
      end
      bfa_pkg::S_FEV: begin
        if (fit_cand) begin
          found <= 1'b1;
          best  <= q_sz;
          where <= off;
        end
        off <= walk_nxt;
      end
      bfa_pkg::S_FEND: begin
        if (!found && !merged) begin
          merged <= 1'b1;
          off    <= '0;
        end
      end
      bfa_pkg::S_MRD: begin
        if (!(off < span)) begin
          off <= '0;
        end
      end
      bfa_pkg::S_MEV: begin
        cur_sz <= q_sz;
        nxt_r  <= walk_nxt;
        if (!(q_free && (walk_nxt < span))) begin
          off <= walk_nxt;
        end
      end
      bfa_pkg::S_MNX: begin
        if (!q_free) begin
          off <= nxt_r;
        end
      end
      bfa_pkg::S_TAKE: begin
        res_granted <= 1'b1;
        res_offset  <= res_offset_calc(where, hdr);
      end
      bfa_pkg::S_HEV: begin
        if ((off == target) && !q_free) begin
          res_granted <= 1'b1;
        end
        off <= walk_nxt;
      end
      default: begin
      end
    endcase
  end

  assign granted       = res_granted;
  assign result_offset = res_offset;
  assign coalesced     = merged;

endmodule

// ----- hdl/bfa_chk.sv -----
// bfa_sva: port-level checks for best_fit_arena_allocator, bound to the top level
// depends on bfa_pkg for port widths

module bfa_sva (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         granted,
  input logic [bfa_pkg::OFFSET_W-1:0] result_offset
);

  // an accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result is one cycle wide and frees the block
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle");

  // a result only follows work in progress or a transaction just taken
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result without a transaction in progress");

  // a refused transaction carries no offset
  a_fail_offset: assert property (@(posedge clk) disable iff (rst)
    (done && !granted) |-> (result_offset == '0))
    else $error("offset reported on a refused transaction");

endmodule

bind best_fit_arena_allocator bfa_sva u_bfa_sva (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .granted       (granted),
  .result_offset (result_offset)
);
